[src/wato_pkg.sv]
// Package with the shared types, constants and helper function of the timeout queue.
`timescale 1ns / 1ps
package wato_pkg;

   localparam int ENTRIES_DEF = 16;
   localparam int NUM_SLOTS   = 16;
   localparam int SLOT_W      = 4;
   localparam int DL_W        = 64;
   localparam int ACT_W       = 2;
   localparam int ERR_W       = 2;

   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
   localparam logic [ERR_W-1:0] ERR_QUEUED     = 2'd1;
   localparam logic [ERR_W-1:0] ERR_NOT_QUEUED = 2'd2;

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

   // a is earlier than b when (a - b) mod 2^64 lies in the upper half of the range.
   function automatic logic is_earlier(input logic [DL_W-1:0] a, input logic [DL_W-1:0] b);
      logic [DL_W-1:0] diff;
      diff = a - b;
      return diff[DL_W-1];
   endfunction

endpackage

[src/wato_ifs.sv]
// Request and response channel interfaces of the timeout queue.
`timescale 1ns / 1ps
interface wato_req_if;
   import wato_pkg::*;
   logic              valid;
   logic              ready;
   logic              opcode;
   logic [SLOT_W-1:0] slot;
   logic [DL_W-1:0]   deadline;
   logic [ACT_W-1:0]  expiry_action;
   modport source (output valid, opcode, slot, deadline, expiry_action, input ready);
   modport sink (input valid, opcode, slot, deadline, expiry_action, output ready);
endinterface

interface wato_rsp_if;
   import wato_pkg::*;
   logic              valid;
   logic              ready;
   logic [ERR_W-1:0]  error_code;
   logic              head_changed;
   logic              head_valid;
   logic [SLOT_W-1:0] head_slot;
   logic [DL_W-1:0]   head_deadline;
   logic [ACT_W-1:0]  head_action;
   modport source (output valid, error_code, head_changed, head_valid, head_slot,
                   head_deadline, head_action, input ready);
   modport sink (input valid, error_code, head_changed, head_valid, head_slot,
                 head_deadline, head_action, output ready);
endinterface

[src/wato_ctrl.sv]
// Controller state machine that sequences capture and commit of each transaction.
`timescale 1ns / 1ps
module wato_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wato_pkg::cmd_type cmd
);
   import wato_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_UPD  = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;

   assign req_ready   = (state_ff == ST_IDLE) && !reset;
   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign cmd.capture = req_valid && req_ready;
   assign cmd.commit  = (state_ff == ST_UPD) && slot_free;
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) state_in = ST_UPD;
         end
         ST_UPD: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_capture_leads_to_update: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == ST_UPD))
      else $error("A captured transaction did not move the controller to the update state.");

   a_commit_only_in_update: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (state_ff == ST_UPD) && !cmd.capture)
      else $error("A commit was issued outside the update state.");

   a_commit_gives_response: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("A committed transaction produced no response.");
`endif

endmodule

[src/wato_dp.sv]
// Datapath holding the ordered entry registers, slot flags and the response register.
`timescale 1ns / 1ps
module wato_dp #(
   parameter int ENTRIES = wato_pkg::ENTRIES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  wato_pkg::cmd_type           cmd,
   input  logic                        req_opcode,
   input  logic [wato_pkg::SLOT_W-1:0] req_slot,
   input  logic [wato_pkg::DL_W-1:0]   req_deadline,
   input  logic [wato_pkg::ACT_W-1:0]  req_expiry_action,
   output logic [wato_pkg::ERR_W-1:0]  rsp_error_code,
   output logic                        rsp_head_changed,
   output logic                        rsp_head_valid,
   output logic [wato_pkg::SLOT_W-1:0] rsp_head_slot,
   output logic [wato_pkg::DL_W-1:0]   rsp_head_deadline,
   output logic [wato_pkg::ACT_W-1:0]  rsp_head_action
);
   import wato_pkg::*;

   localparam int CNT_W = $clog2(ENTRIES + 1);

   logic [SLOT_W-1:0] slots_ff [ENTRIES];
   logic [SLOT_W-1:0] slots_in [ENTRIES];
   logic [DL_W-1:0]   dls_ff   [ENTRIES];
   logic [DL_W-1:0]   dls_in   [ENTRIES];
   logic [ACT_W-1:0]  acts_ff  [ENTRIES];
   logic [ACT_W-1:0]  acts_in  [ENTRIES];

   logic [CNT_W-1:0]     count_ff, count_in;
   logic [NUM_SLOTS-1:0] queued_ff, queued_in;

   logic              op_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [DL_W-1:0]   dl_ff;
   logic [ACT_W-1:0]  act_ff;
   logic [ENTRIES-1:0] hit_ff, hit_in;
   logic [ERR_W-1:0]  err_ff, err_in;
   logic              full_ff, full_in;

   logic [ENTRIES-1:0] hit_dec, below, first;
   logic               none, apply, changed;

   logic [ERR_W-1:0]  rsp_err_ff;
   logic              rsp_chg_ff, rsp_hv_ff;
   logic [SLOT_W-1:0] rsp_hs_ff;
   logic [DL_W-1:0]   rsp_hd_ff;
   logic [ACT_W-1:0]  rsp_ha_ff;

   // Parallel compare of the incoming transaction against every occupied entry.
   for (genvar i = 0; i < ENTRIES; i++) begin : g_hit
      assign hit_in[i] = (CNT_W'(i) < count_ff) &&
                         ((req_opcode == OP_ENQ) ? is_earlier(req_deadline, dls_ff[i])
                                                 : (slots_ff[i] == req_slot));
   end

   always_comb begin
      err_in = ERR_NONE;
      if (req_opcode == OP_ENQ && queued_ff[req_slot]) err_in = ERR_QUEUED;
      if (req_opcode == OP_DEQ && !queued_ff[req_slot]) err_in = ERR_NOT_QUEUED;
   end

   assign full_in = (count_ff == CNT_W'(ENTRIES));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_opcode;
         slot_ff <= req_slot;
         dl_ff   <= req_deadline;
         act_ff  <= req_expiry_action;
         hit_ff  <= hit_in;
         err_ff  <= err_in;
         full_ff <= full_in;
      end
   end

   // Bits below the first hit, and the first hit itself, found with one subtraction.
   assign hit_dec = hit_ff - {{(ENTRIES - 1){1'b0}}, 1'b1};
   assign below   = hit_dec & ~hit_ff;
   assign first   = hit_ff & ~hit_dec;
   assign none    = (hit_ff == '0);
   assign apply   = (err_ff == ERR_NONE) && !(op_ff == OP_ENQ && full_ff);

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic [SLOT_W-1:0] s_prev, s_next;
      logic [DL_W-1:0]   d_prev, d_next;
      logic [ACT_W-1:0]  a_prev, a_next;
      logic              new_here, shift_up, shift_down;

      if (i == 0) begin : g_low
         assign s_prev = slots_ff[i];
         assign d_prev = dls_ff[i];
         assign a_prev = acts_ff[i];
      end else begin : g_low
         assign s_prev = slots_ff[i-1];
         assign d_prev = dls_ff[i-1];
         assign a_prev = acts_ff[i-1];
      end

      if (i == ENTRIES - 1) begin : g_high
         assign s_next = slots_ff[i];
         assign d_next = dls_ff[i];
         assign a_next = acts_ff[i];
      end else begin : g_high
         assign s_next = slots_ff[i+1];
         assign d_next = dls_ff[i+1];
         assign a_next = acts_ff[i+1];
      end

      assign new_here   = first[i] || (none && (count_ff == CNT_W'(i)));
      assign shift_up   = !below[i] && !first[i];
      assign shift_down = !below[i];

      always_comb begin
         slots_in[i] = slots_ff[i];
         dls_in[i]   = dls_ff[i];
         acts_in[i]  = acts_ff[i];
         if (apply) begin
            if (op_ff == OP_ENQ) begin
               if (new_here) begin
                  slots_in[i] = slot_ff;
                  dls_in[i]   = dl_ff;
                  acts_in[i]  = act_ff;
               end else if (shift_up) begin
                  slots_in[i] = s_prev;
                  dls_in[i]   = d_prev;
                  acts_in[i]  = a_prev;
               end
            end else if (shift_down) begin
               slots_in[i] = s_next;
               dls_in[i]   = d_next;
               acts_in[i]  = a_next;
            end
         end
      end
   end

   always_comb begin
      count_in  = count_ff;
      queued_in = queued_ff;
      changed   = 1'b0;
      if (apply) begin
         if (op_ff == OP_ENQ) begin
            count_in           = count_ff + CNT_W'(1);
            queued_in[slot_ff] = 1'b1;
            changed            = first[0] || (none && (count_ff == '0));
         end else begin
            if (!none) count_in = count_ff - CNT_W'(1);
            queued_in[slot_ff] = 1'b0;
            changed            = first[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         slots_ff <= slots_in;
         dls_ff   <= dls_in;
         acts_ff  <= acts_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         queued_ff <= '0;
      end else if (cmd.commit) begin
         count_ff  <= count_in;
         queued_ff <= queued_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_err_ff <= err_ff;
         rsp_chg_ff <= changed;
         rsp_hv_ff  <= (count_in != '0);
         rsp_hs_ff  <= (count_in != '0) ? slots_in[0] : '0;
         rsp_hd_ff  <= (count_in != '0) ? dls_in[0] : '0;
         rsp_ha_ff  <= (count_in != '0) ? acts_in[0] : '0;
      end
   end

   assign rsp_error_code    = rsp_err_ff;
   assign rsp_head_changed  = rsp_chg_ff;
   assign rsp_head_valid    = rsp_hv_ff;
   assign rsp_head_slot     = rsp_hs_ff;
   assign rsp_head_deadline = rsp_hd_ff;
   assign rsp_head_action   = rsp_ha_ff;

`ifndef SYNTH
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("The entry count exceeds the queue depth.");

   a_flags_match_count: assert property (@(posedge clock) disable iff (reset)
      $countones(queued_ff) == int'(count_ff))
      else $error("The number of queued slots differs from the entry count.");

   a_state_held_between_commits: assert property (@(posedge clock) disable iff (reset)
      (!reset && !cmd.commit) |=> $stable(count_ff) && $stable(queued_ff))
      else $error("The queue state changed without a commit.");
`endif

endmodule

[src/wrap_aware_timeout_queue.sv]
// Top level of the wrap-aware timeout queue: an ordered list of watchdog deadlines.
// The req_if channel carries enqueue and dequeue transactions for one of 16 slots;
// the rsp_if channel returns exactly one response per transaction, reporting the
// error code, whether the head changed, and the slot, deadline and action at the head.
// Deadlines are ordered with wrap-around, and equal deadlines keep arrival order.
// Each transaction is handled in order: the accept edge registers a parallel compare of
// the request against every stored entry, and the commit edge shifts the ordered
// register array and loads the response register. A response becomes valid once its
// update is committed, and no new request is accepted until the pending update has
// committed. The response register decouples the two channels, so a new
// request is taken while the previous response still waits; if the receiver stalls,
// the pending update waits in its state until the response register is free.
// Reset is synchronous and empties the queue and all slot flags at once; the entry
// registers themselves are not cleared and need no clearing pass.
`timescale 1ns / 1ps
module wrap_aware_timeout_queue #(
   parameter int ENTRIES = wato_pkg::ENTRIES_DEF
) (
   input logic         clock,
   input logic         reset,
   wato_req_if.sink    req_if,
   wato_rsp_if.source  rsp_if
);
   import wato_pkg::*;

   cmd_type cmd;

   wato_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   wato_dp #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_opcode        (req_if.opcode),
      .req_slot          (req_if.slot),
      .req_deadline      (req_if.deadline),
      .req_expiry_action (req_if.expiry_action),
      .rsp_error_code    (rsp_if.error_code),
      .rsp_head_changed  (rsp_if.head_changed),
      .rsp_head_valid    (rsp_if.head_valid),
      .rsp_head_slot     (rsp_if.head_slot),
      .rsp_head_deadline (rsp_if.head_deadline),
      .rsp_head_action   (rsp_if.head_action)
   );

endmodule

[test/wrap_aware_timeout_queue_test.sv]
// Self-checking testbench for the wrap-aware timeout queue, with a predictor of the sorted list.
`timescale 1ns / 1ps
module wrap_aware_timeout_queue_test;
   import wato_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 600;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [DL_W-1:0] DL_MAX  = 64'hffff_ffff_ffff_ffff;
   localparam logic [DL_W-1:0] DL_HALF = 64'h7fff_ffff_ffff_ffff;
   localparam logic [DL_W-1:0] DL_WRAP = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [ERR_W-1:0]  error_code;
      logic              head_changed;
      logic              head_valid;
      logic [SLOT_W-1:0] head_slot;
      logic [DL_W-1:0]   head_deadline;
      logic [ACT_W-1:0]  head_action;
   } head_report_type;

   typedef struct packed {
      logic              opcode;
      logic [SLOT_W-1:0] slot;
      logic [DL_W-1:0]   deadline;
      logic [ACT_W-1:0]  expiry_action;
      logic              typed;
      head_report_type   want;
   } timer_op_row_type;

   localparam head_report_type PREDICTED = '0;
   localparam int DIRECTED_ROWS = 22;

   // Rows with typed set carry their own expected head report; the others use the predictor.
   timer_op_row_type directed_ops [DIRECTED_ROWS] = '{
      '{OP_DEQ, 4'd0,  64'd0,   2'd0, 1'b1, '{ERR_NOT_QUEUED, 1'b0, 1'b0, 4'd0, 64'd0, 2'd0}},
      '{OP_ENQ, 4'd15, DL_MAX,  2'd3, 1'b1, '{ERR_NONE, 1'b1, 1'b1, 4'd15, DL_MAX, 2'd3}},
      '{OP_ENQ, 4'd15, 64'd0,   2'd0, 1'b1, '{ERR_QUEUED, 1'b0, 1'b1, 4'd15, DL_MAX, 2'd3}},
      '{OP_ENQ, 4'd0,  64'd0,   2'd0, 1'b0, PREDICTED},
      '{OP_ENQ, 4'd1,  DL_HALF, 2'd1, 1'b0, PREDICTED},
      '{OP_ENQ, 4'd2,  DL_WRAP, 2'd2, 1'b0, PREDICTED},
      '{OP_ENQ, 4'd3,  DL_MAX,  2'd1, 1'b0, PREDICTED},
      '{OP_ENQ, 4'd4,  DL_WRAP, 2'd3, 1'b0, PREDICTED},
      '{OP_DEQ, 4'd3,  64'd0,   2'd0, 1'b0, PREDICTED},
      '{OP_DEQ, 4'd3,  64'd0,   2'd0, 1'b0, PREDICTED},
      '{OP_DEQ, 4'd2,  64'd0,   2'd0, 1'b0, PREDICTED},
      '{OP_DEQ, 4'd4,  64'd0,   2'd0, 1'b0, PREDICTED},
      '{OP_DEQ, 4'd15, 64'd0,   2'd0, 1'b0, PREDICTED},
      '{OP_DEQ, 4'd0,  64'd0,   2'd0, 1'b0, PREDICTED},
      '{OP_DEQ, 4'd1,  64'd0,   2'd0, 1'b0, PREDICTED},
      '{OP_ENQ, 4'd7,  64'h0123_4567_89ab_cdef, 2'd2, 1'b1,
        '{ERR_NONE, 1'b1, 1'b1, 4'd7, 64'h0123_4567_89ab_cdef, 2'd2}},
      '{OP_DEQ, 4'd7,  64'd0,   2'd0, 1'b1, '{ERR_NONE, 1'b1, 1'b0, 4'd0, 64'd0, 2'd0}},
      '{OP_DEQ, 4'd15, 64'd0,   2'd0, 1'b1, '{ERR_NOT_QUEUED, 1'b0, 1'b0, 4'd0, 64'd0, 2'd0}},
      '{OP_ENQ, 4'd8,  64'd5,   2'd1, 1'b0, PREDICTED},
      '{OP_ENQ, 4'd9,  64'd5,   2'd2, 1'b0, PREDICTED},
      '{OP_DEQ, 4'd8,  64'd0,   2'd0, 1'b0, PREDICTED},
      '{OP_DEQ, 4'd9,  64'd0,   2'd0, 1'b1, '{ERR_NONE, 1'b1, 1'b0, 4'd0, 64'd0, 2'd0}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   failures = 0;
   int   cycle_count = 0;

   logic [SLOT_W-1:0] sorted_slot     [ENTRIES_DEF];
   logic [DL_W-1:0]   sorted_deadline [ENTRIES_DEF];
   logic [ACT_W-1:0]  sorted_action   [ENTRIES_DEF];
   logic              slot_armed      [NUM_SLOTS];
   int                armed_count = 0;

   head_report_type expected_heads [$];

   wato_req_if req_ch ();
   wato_rsp_if rsp_ch ();

   wrap_aware_timeout_queue dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic head_report_type apply_timer_op(input logic op,
                                                      input logic [SLOT_W-1:0] s,
                                                      input logic [DL_W-1:0] dl,
                                                      input logic [ACT_W-1:0] act);
      head_report_type rep;
      logic [DL_W-1:0] diff;
      int pos;
      rep = '0;
      pos = 0;
      if (op == OP_ENQ) begin
         if (slot_armed[s]) begin
            rep.error_code = ERR_QUEUED;
         end else if (armed_count < ENTRIES_DEF) begin
            while (pos < armed_count) begin
               diff = dl - sorted_deadline[pos];
               if (diff[DL_W-1]) break;
               pos++;
            end
            for (int i = armed_count; i > pos; i--) begin
               sorted_slot[i]     = sorted_slot[i-1];
               sorted_deadline[i] = sorted_deadline[i-1];
               sorted_action[i]   = sorted_action[i-1];
            end
            sorted_slot[pos]     = s;
            sorted_deadline[pos] = dl;
            sorted_action[pos]   = act;
            armed_count++;
            slot_armed[s] = 1'b1;
            rep.head_changed = (pos == 0);
         end
      end else begin
         if (!slot_armed[s]) begin
            rep.error_code = ERR_NOT_QUEUED;
         end else begin
            while (pos < armed_count && sorted_slot[pos] != s) pos++;
            if (pos < armed_count) begin
               for (int i = pos; i + 1 < armed_count; i++) begin
                  sorted_slot[i]     = sorted_slot[i+1];
                  sorted_deadline[i] = sorted_deadline[i+1];
                  sorted_action[i]   = sorted_action[i+1];
               end
               armed_count--;
               rep.head_changed = (pos == 0);
            end
            slot_armed[s] = 1'b0;
         end
      end
      if (armed_count > 0) begin
         rep.head_valid    = 1'b1;
         rep.head_slot     = sorted_slot[0];
         rep.head_deadline = sorted_deadline[0];
         rep.head_action   = sorted_action[0];
      end
      return rep;
   endfunction

   task automatic send_timer_op(input logic op, input logic [SLOT_W-1:0] s,
                                input logic [DL_W-1:0] dl, input logic [ACT_W-1:0] act,
                                input logic typed, input head_report_type want);
      head_report_type predicted;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.opcode        <= op;
      req_ch.slot          <= s;
      req_ch.deadline      <= dl;
      req_ch.expiry_action <= act;
      do @(posedge clock); while (!req_ch.ready);
      predicted = apply_timer_op(op, s, dl, act);
      expected_heads.push_back(typed ? want : predicted);
   endtask

   task automatic compare_field(input string name, input logic [DL_W-1:0] want,
                                input logic [DL_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      head_report_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_heads.size() == 0) begin
            $display("%0t: response with none outstanding, expected nothing, actual slot %0h",
                     $time, rsp_ch.head_slot);
            failures++;
         end else begin
            want = expected_heads.pop_front();
            compare_field("error_code", DL_W'(want.error_code), DL_W'(rsp_ch.error_code));
            compare_field("head_changed", DL_W'(want.head_changed),
                          DL_W'(rsp_ch.head_changed));
            compare_field("head_valid", DL_W'(want.head_valid), DL_W'(rsp_ch.head_valid));
            compare_field("head_slot", DL_W'(want.head_slot), DL_W'(rsp_ch.head_slot));
            compare_field("head_deadline", want.head_deadline, rsp_ch.head_deadline);
            compare_field("head_action", DL_W'(want.head_action), DL_W'(rsp_ch.head_action));
         end
      end
      rsp_ch.ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      logic              op;
      logic [SLOT_W-1:0] s;
      logic [DL_W-1:0]   dl;
      logic [DL_W-1:0]   base;
      logic [SLOT_W-1:0] free_slots [NUM_SLOTS];
      logic [SLOT_W-1:0] busy_slots [NUM_SLOTS];
      int free_n;
      int busy_n;
      int fill_target;
      logic want_enq;

      for (int i = 0; i < NUM_SLOTS; i++) slot_armed[i] = 1'b0;
      req_ch.valid         = 1'b0;
      req_ch.opcode        = OP_ENQ;
      req_ch.slot          = '0;
      req_ch.deadline      = '0;
      req_ch.expiry_action = '0;
      rsp_ch.ready         = 1'b0;
      fill_target = 8;
      base = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 49 : 0;
         recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 37 : 0;
         if (phase == 0) begin
            foreach (directed_ops[i])
               send_timer_op(directed_ops[i].opcode, directed_ops[i].slot,
                             directed_ops[i].deadline, directed_ops[i].expiry_action,
                             directed_ops[i].typed, directed_ops[i].want);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0) begin
               fill_target = $urandom_range(ENTRIES_DEF);
               base = {$urandom, $urandom};
            end
            case ($urandom_range(3))
               0: dl = {$urandom, $urandom};
               1: dl = base + DL_W'($urandom_range(7));
               2: dl = base + DL_WRAP + DL_W'($urandom_range(7)) - DL_W'(4);
               default: begin
                  case ($urandom_range(3))
                     0: dl = '0;
                     1: dl = DL_MAX;
                     2: dl = DL_HALF;
                     default: dl = DL_WRAP;
                  endcase
               end
            endcase
            if ($urandom_range(99) < 10) begin
               op = 1'($urandom_range(1));
               s  = SLOT_W'($urandom_range(NUM_SLOTS - 1));
            end else begin
               free_n = 0;
               busy_n = 0;
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (slot_armed[i]) busy_slots[busy_n++] = SLOT_W'(i);
                  else free_slots[free_n++] = SLOT_W'(i);
               end
               want_enq = (armed_count < fill_target) || (busy_n == 0);
               if (free_n == 0 || armed_count >= ENTRIES_DEF) want_enq = 1'b0;
               op = want_enq ? OP_ENQ : OP_DEQ;
               s  = want_enq ? free_slots[$urandom_range(free_n - 1)]
                             : busy_slots[$urandom_range(busy_n - 1)];
            end
            send_timer_op(op, s, dl, ACT_W'($urandom_range(3)), 1'b0, PREDICTED);
         end
         // Hold the request channel quiet until every response of this phase is back.
         req_ch.valid <= 1'b0;
         while (expected_heads.size() != 0) @(posedge clock);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && expected_heads.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
